// ===== hw/rtl/psmv_pkg.sv =====
`timescale 1ns / 1ps

package psmv_pkg;

	localparam int unsigned IDX_W  = 4;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned SIZE_W = 5;
	localparam int unsigned PROD_W = 2 * VAL_W;
	localparam int unsigned ACC_W  = PROD_W + IDX_W;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned SLOT_W = 8;

	localparam logic CMD_MATRIX = 1'b0;
	localparam logic CMD_VECTOR = 1'b1;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	// lower-triangle slot shared by (r,c) and (c,r)
	function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		logic [IDX_W-1:0]  hi;
		logic [IDX_W-1:0]  lo;
		logic [SLOT_W-1:0] tri_base;
		hi       = (r > c) ? r : c;
		lo       = (r > c) ? c : r;
		tri_base = (SLOT_W'(hi) * (SLOT_W'(hi) + SLOT_W'(1))) >> 1;
		return tri_base + SLOT_W'(lo);
	endfunction

endpackage

// ===== hw/rtl/psmv_mem.sv =====
`timescale 1ns / 1ps

module psmv_mem #(
	parameter int unsigned DEPTH = 136
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [psmv_pkg::VAL_W-1:0]     wdata,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [psmv_pkg::VAL_W-1:0]     rdata
);
	import psmv_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [VAL_W-1:0] rd_s1;
	logic             rd_vld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_s1 ? rd_s1 : '0;

endmodule

// ===== hw/rtl/psmv_mac.sv =====
`timescale 1ns / 1ps

module psmv_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  psmv_pkg::mac_ctl_t                ctl_s1,
	input  logic signed [psmv_pkg::VAL_W-1:0] a_s1,
	input  logic signed [psmv_pkg::VAL_W-1:0] b_s1,
	output logic        [psmv_pkg::VAL_W-1:0] res,
	output logic                              done
);
	import psmv_pkg::*;

	localparam int unsigned SH_W = ACC_W - FRAC_W;

	mac_ctl_t                 ctl_s2;
	mac_ctl_t                 ctl_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic        [ACC_W-1:0]  rnd;
	logic        [SH_W-1:0]   sh;
	logic        [VAL_W-1:0]  sat;
	logic        [VAL_W-1:0]  res_q;
	logic                     done_q;

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= {{IDX_W{prod_s2[PROD_W-1]}}, prod_s2};
			end else begin
				acc_q <= acc_q + {{IDX_W{prod_s2[PROD_W-1]}}, prod_s2};
			end
		end
		if (ctl_s3.valid && ctl_s3.last) begin
			res_q <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			done_q <= ctl_s3.valid & ctl_s3.last;
		end
	end

	// round half up to q16.16, then clamp
	always_comb begin
		rnd = acc_q + {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
		sh  = rnd[ACC_W-1:FRAC_W];
		if (!sh[SH_W-1] && (|sh[SH_W-2:VAL_W-1])) begin
			sat = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (sh[SH_W-1] && !(&sh[SH_W-2:VAL_W-1])) begin
			sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat = sh[VAL_W-1:0];
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/packed_symmetric_matvec.sv =====
`timescale 1ns / 1ps
// matrix writes and non-final vector writes are accepted whenever the block is idle
// a vector word at index size-1 (clamped to 0..MAX_ROWS-1) starts the product:
// each row is issued entry by entry through the shared multiply-accumulate unit,
// drains its pipeline and is emitted, waiting while result_stall holds a result;
// no new word is taken until the last result is registered
// reset zeroes the matrix (per-entry valid bits) and the vector, and sets size to 6
module packed_symmetric_matvec #(
	parameter int unsigned MAX_ROWS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [psmv_pkg::SIZE_W-1:0]       cfg_wr_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              cmd,
	input  logic [psmv_pkg::IDX_W-1:0]        row,
	input  logic [psmv_pkg::IDX_W-1:0]        col,
	input  logic signed [psmv_pkg::VAL_W-1:0] value,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [psmv_pkg::VAL_W-1:0] result_value,
	output logic [psmv_pkg::IDX_W-1:0]        result_index,
	output logic                              last
);
	import psmv_pkg::*;

	localparam int unsigned DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned IW    = $clog2(MAX_ROWS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] size_q;
	logic [IW-1:0]     last_idx;
	logic [IW-1:0]     i_q;
	logic [IW-1:0]     j_q;
	mac_ctl_t          ctl_s1;
	logic [VAL_W-1:0]  vec_q [MAX_ROWS];
	logic [VAL_W-1:0]  x_s1;
	logic [VAL_W-1:0]  mat_s1;
	logic [VAL_W-1:0]  mac_res;
	logic              mac_done;
	logic              accept;
	logic              row_ok;
	logic              col_ok;
	logic              mat_we;
	logic              vec_we;
	logic              start;
	logic              out_free;
	logic [VAL_W-1:0]  res_value_q;
	logic [IW-1:0]     res_index_q;
	logic              res_last_q;
	logic              res_valid_q;

	always_comb begin
		if (size_q == '0) begin
			last_idx = '0;
		end else if (size_q > SIZE_W'(MAX_ROWS)) begin
			last_idx = IW'(MAX_ROWS - 1);
		end else begin
			last_idx = IW'(size_q - SIZE_W'(1));
		end
	end

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid & ~item_stall;
	assign row_ok     = {1'b0, row} < SIZE_W'(MAX_ROWS);
	assign col_ok     = {1'b0, col} < SIZE_W'(MAX_ROWS);
	assign mat_we     = accept && (cmd == CMD_MATRIX) && row_ok && col_ok;
	assign vec_we     = accept && (cmd == CMD_VECTOR) && col_ok;
	assign start      = vec_we && (col[IW-1:0] == last_idx);
	assign out_free   = ~res_valid_q | ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(6);
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_ROWS; k++) begin
				vec_q[k] <= '0;
			end
		end else if (vec_we) begin
			vec_q[col[IW-1:0]] <= value;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= vec_q[j_q];
	end

	psmv_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mat_we),
		.waddr (AW'(slot_of(row, col))),
		.wdata (value),
		.raddr (AW'(slot_of(IDX_W'(i_q), IDX_W'(j_q)))),
		.rdata (mat_s1)
	);

	psmv_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl_s1(ctl_s1),
		.a_s1  (mat_s1),
		.b_s1  (x_s1),
		.res   (mac_res),
		.done  (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			ctl_s1      <= '0;
			res_valid_q <= 1'b0;
			res_value_q <= '0;
			res_index_q <= '0;
			res_last_q  <= 1'b0;
		end else begin
			if (state_q == S_ISSUE) begin
				ctl_s1 <= '{valid: 1'b1, first: (j_q == '0),
						last: (j_q == last_idx)};
			end else begin
				ctl_s1 <= '0;
			end
			if ((state_q == S_EMIT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (j_q == last_idx) begin
						state_q <= S_WAIT;
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				S_WAIT: begin
					if (mac_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						res_value_q <= mac_res;
						res_index_q <= i_q;
						res_last_q  <= (i_q == last_idx);
						if (i_q == last_idx) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + IW'(1);
							j_q     <= '0;
							state_q <= S_ISSUE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result_value = res_value_q;
	assign result_index = IDX_W'(res_index_q);
	assign last         = res_last_q;

endmodule
